FILE: hw/rtl/half_duplex_link_controller_top_macros.svh
// Assertion macros for the half-duplex link controller.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef HALF_DUPLEX_LINK_CONTROLLER_TOP_MACROS_SVH
`define HALF_DUPLEX_LINK_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HDX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define HDX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/hdx_pkg.sv
// Shared types, codes and helper functions for the half-duplex link controller.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package hdx_pkg;

    localparam int unsigned TO_W   = 20;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned FAC_W  = 4;
    localparam int unsigned IDX_W  = 3;

    // Register reset values
    localparam logic [TO_W-1:0]  IDLE_TO_RST  = 20'd1000;
    localparam logic [TO_W-1:0]  BID_TO_RST   = 20'd500;
    localparam logic [TO_W-1:0]  SEND_TO_RST  = 20'd500;
    localparam logic [TO_W-1:0]  RECV_TO_RST  = 20'd500;
    localparam logic [FAC_W-1:0] SEND_BF_RST  = 4'd2;
    localparam logic [FAC_W-1:0] RECV_BF_RST  = 4'd2;
    localparam logic [CNT_W-1:0] MAX_TO_RST   = 8'd3;
    localparam logic [CNT_W-1:0] MAX_FB_RST   = 8'd3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_IDLE_TO = 3'd0;
    localparam logic [IDX_W-1:0] CFG_BID_TO  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SEND_TO = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RECV_TO = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SEND_BF = 3'd4;
    localparam logic [IDX_W-1:0] CFG_RECV_BF = 3'd5;
    localparam logic [IDX_W-1:0] CFG_MAX_TO  = 3'd6;
    localparam logic [IDX_W-1:0] CFG_MAX_FB  = 3'd7;

    // Operation codes
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Control character classes
    localparam logic [2:0] K_ACK = 3'd1;
    localparam logic [2:0] K_ENQ = 3'd2;
    localparam logic [2:0] K_EOT = 3'd3;
    localparam logic [2:0] K_RVI = 3'd4;

    // Send codes
    localparam logic [2:0] SND_NONE = 3'd0;
    localparam logic [2:0] SND_ACK  = 3'd1;
    localparam logic [2:0] SND_ENQ  = 3'd2;
    localparam logic [2:0] SND_EOT  = 3'd3;
    localparam logic [2:0] SND_RVI  = 3'd4;
    localparam logic [2:0] SND_DATA = 3'd5;

    // Read classifications
    localparam logic [2:0] RR_TIMEOUT  = 3'd0;
    localparam logic [2:0] RR_CTRL     = 3'd1;
    localparam logic [2:0] RR_DATA     = 3'd2;
    localparam logic [2:0] RR_UNFINISH = 3'd3;
    localparam logic [2:0] RR_INVALID  = 3'd4;

    // External state codes
    localparam logic [1:0] CODE_SEND = 2'd0;
    localparam logic [1:0] CODE_BID  = 2'd1;
    localparam logic [1:0] CODE_IDLE = 2'd2;
    localparam logic [1:0] CODE_RECV = 2'd3;

    localparam logic [TO_W-1:0]  TO_MAX  = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_BID  = 4'b0010,
        ST_SEND = 4'b0100,
        ST_RECV = 4'b1000
    } t_link_state;

    typedef struct packed {
        logic [TO_W-1:0]  idle_to;
        logic [TO_W-1:0]  bid_to;
        logic [TO_W-1:0]  send_to;
        logic [TO_W-1:0]  recv_to;
        logic [FAC_W-1:0] send_bf;
        logic [FAC_W-1:0] recv_bf;
        logic [CNT_W-1:0] max_to;
        logic [CNT_W-1:0] max_fb;
    } t_cfg;

    typedef struct packed {
        logic       operation;
        logic [2:0] ctrl_kind;
        logic       lead_is_soh;
        logic       frame_complete;
        logic       crc_ok;
        logic [7:0] seq_byte;
        logic [7:0] tx_count;
    } t_item;

    typedef struct packed {
        logic [2:0]      send_code;
        logic            pop_tx;
        logic            deliver_rx;
        logic [2:0]      read_result;
        logic [1:0]      next_state;
        logic [TO_W-1:0] timeout_value;
        logic            disconnect;
    } t_result;

    typedef struct packed {
        t_link_state      st;
        logic [TO_W-1:0]  tmo;
        logic [CNT_W-1:0] tcnt;
        logic [CNT_W-1:0] fbcnt;
        logic             seq;
    } t_link;

    // Timeout times backoff factor, saturating at the top of the range
    function automatic logic [TO_W-1:0] sat_mul(logic [TO_W-1:0] t, logic [FAC_W-1:0] f);
        logic [TO_W+FAC_W-1:0] p;
        p = {{FAC_W{1'b0}}, t} * {{TO_W{1'b0}}, f};
        return (p[TO_W+FAC_W-1:TO_W] != '0) ? TO_MAX : p[TO_W-1:0];
    endfunction

    // Saturating counter step
    function automatic logic [CNT_W-1:0] inc_sat(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

    // Map the one-hot state to its external code
    function automatic logic [1:0] enc_state(t_link_state s);
        logic [1:0] c;
        unique case (s)
            ST_SEND: c = CODE_SEND;
            ST_BID:  c = CODE_BID;
            ST_IDLE: c = CODE_IDLE;
            ST_RECV: c = CODE_RECV;
            default: c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/half_duplex_link_controller_top.sv
// A request accepted into the input register moves on, with its decision, into the result
// register when that register is empty or being emptied. Throughput: one request per cycle
// while the output is not stalled; the combinational decision over the registered link state
// sets the rate. While a result is stalled, one more request waits in the input register.
// Reset: synchronous, active low; link goes idle with the idle timeout, counters and the
// sequence bit clear, configuration registers take their defaults, both stages empty.
`timescale 1ns / 1ps
`include "half_duplex_link_controller_top_macros.svh"

module half_duplex_link_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hdx_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [hdx_pkg::TO_W-1:0]       i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic [2:0]                     i_ctrl_kind,
    input  logic                           i_lead_is_soh,
    input  logic                           i_frame_complete,
    input  logic                           i_crc_ok,
    input  logic [7:0]                     i_seq_byte,
    input  logic [7:0]                     i_tx_count,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_send_code,
    output logic                           o_pop_tx,
    output logic                           o_deliver_rx,
    output logic [2:0]                     o_read_result,
    output logic [1:0]                     o_next_state,
    output logic [hdx_pkg::TO_W-1:0]       o_timeout_value,
    output logic                           o_disconnect
);
    import hdx_pkg::*;

    t_cfg    w_cfg;
    t_item   r_item;
    t_result w_res;
    t_result r_res;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    w_adv;
    logic    w_accept;

    hdx_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Move a request on when the result register is empty or being emptied
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Input register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_adv);
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.operation      <= i_operation;
            r_item.ctrl_kind      <= i_ctrl_kind;
            r_item.lead_is_soh    <= i_lead_is_soh;
            r_item.frame_complete <= i_frame_complete;
            r_item.crc_ok         <= i_crc_ok;
            r_item.seq_byte       <= i_seq_byte;
            r_item.tx_count       <= i_tx_count;
        end
    end

    hdx_link_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (w_cfg),
        .i_item  (r_item),
        .o_res   (w_res)
    );

    // Result register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_adv || (r_out_valid && i_out_stall);
        end
    end

    // Result register: payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_send_code     = r_res.send_code;
    assign o_pop_tx        = r_res.pop_tx;
    assign o_deliver_rx    = r_res.deliver_rx;
    assign o_read_result   = r_res.read_result;
    assign o_next_state    = r_res.next_state;
    assign o_timeout_value = r_res.timeout_value;
    assign o_disconnect    = r_res.disconnect;

    // Checks on the pipeline and on result consistency
    `HDX_ASSERT_NXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid,
        "advanced request lost")
    `HDX_ASSERT_IMP(a_full_stall_back, i_clk, i_rst_n,
        r_in_valid && r_out_valid && i_out_stall, o_in_stall,
        "input taken while both stages blocked")
    `HDX_ASSERT_IMP(a_disc_to_idle, i_clk, i_rst_n, r_out_valid && r_res.disconnect,
        r_res.next_state == CODE_IDLE, "disconnect without return to idle")
    `HDX_ASSERT_IMP(a_pop_on_ctrl, i_clk, i_rst_n, r_out_valid && r_res.pop_tx,
        r_res.read_result == RR_CTRL, "pop without a consumed control frame")
    `HDX_ASSERT_IMP(a_deliver_on_data, i_clk, i_rst_n, r_out_valid && r_res.deliver_rx,
        r_res.read_result == RR_DATA, "delivery without a consumed data frame")

endmodule

FILE: hw/rtl/hdx_cfg_regs.sv
// Configuration register file of the half-duplex link controller.
// Depends on hdx_pkg for the register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module hdx_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hdx_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [hdx_pkg::TO_W-1:0]       i_cfg_data,
    output hdx_pkg::t_cfg                  o_cfg
);
    import hdx_pkg::*;

    t_cfg r_cfg;

    // Load defaults on reset, then write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_to <= IDLE_TO_RST;
            r_cfg.bid_to  <= BID_TO_RST;
            r_cfg.send_to <= SEND_TO_RST;
            r_cfg.recv_to <= RECV_TO_RST;
            r_cfg.send_bf <= SEND_BF_RST;
            r_cfg.recv_bf <= RECV_BF_RST;
            r_cfg.max_to  <= MAX_TO_RST;
            r_cfg.max_fb  <= MAX_FB_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDLE_TO: r_cfg.idle_to <= i_cfg_data;
                CFG_BID_TO:  r_cfg.bid_to  <= i_cfg_data;
                CFG_SEND_TO: r_cfg.send_to <= i_cfg_data;
                CFG_RECV_TO: r_cfg.recv_to <= i_cfg_data;
                CFG_SEND_BF: r_cfg.send_bf <= i_cfg_data[FAC_W-1:0];
                CFG_RECV_BF: r_cfg.recv_bf <= i_cfg_data[FAC_W-1:0];
                CFG_MAX_TO:  r_cfg.max_to  <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_FB:  r_cfg.max_fb  <= i_cfg_data[CNT_W-1:0];
                default:     r_cfg.idle_to <= r_cfg.idle_to;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/hdx_link_fsm.sv
// Link state machine: holds state, timeout and counters, decides each request.
// Depends on hdx_pkg for types, codes, sat_mul, inc_sat and enc_state.
`timescale 1ns / 1ps

module hdx_link_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  hdx_pkg::t_cfg    i_cfg,
    input  hdx_pkg::t_item   i_item,
    output hdx_pkg::t_result o_res
);
    import hdx_pkg::*;

    t_link            r_link;
    t_link            n_link;
    t_result          w_res;
    logic [TO_W-1:0]  w_tmo_send_bo;
    logic [TO_W-1:0]  w_tmo_recv_bo;
    logic [CNT_W-1:0] w_tcnt_inc;
    logic [CNT_W-1:0] w_fb_inc;
    logic [7:0]       w_left;
    logic             w_have_tx;

    // Backoff products and counter steps
    assign w_tmo_send_bo = sat_mul(r_link.tmo, i_cfg.send_bf);
    assign w_tmo_recv_bo = sat_mul(r_link.tmo, i_cfg.recv_bf);
    assign w_tcnt_inc    = inc_sat(r_link.tcnt);
    assign w_fb_inc      = inc_sat(r_link.fbcnt);
    assign w_have_tx     = (i_item.tx_count != 8'd0);
    assign w_left        = w_have_tx ? (i_item.tx_count - 8'd1) : 8'd0;

    // Decide next state and result for the request in the input register
    always_comb begin
        n_link            = r_link;
        w_res.send_code   = SND_NONE;
        w_res.pop_tx      = 1'b0;
        w_res.deliver_rx  = 1'b0;
        w_res.read_result = RR_TIMEOUT;
        w_res.disconnect  = 1'b0;

        if (i_item.operation == OP_TIMEOUT) begin
            unique case (r_link.st)
                ST_IDLE: begin
                    w_res.send_code = SND_ENQ;
                    n_link.tmo      = i_cfg.bid_to;
                    n_link.st       = ST_BID;
                end
                ST_BID: begin
                    n_link.fbcnt     = w_fb_inc;
                    w_res.disconnect = (w_fb_inc >= i_cfg.max_fb);
                    n_link.tmo       = i_cfg.idle_to;
                    n_link.st        = ST_IDLE;
                end
                ST_SEND: begin
                    n_link.tmo  = w_tmo_send_bo;
                    n_link.tcnt = w_tcnt_inc;
                    if (w_tcnt_inc >= i_cfg.max_to) begin
                        n_link.tmo = i_cfg.idle_to;
                        n_link.st  = ST_IDLE;
                    end else if (!w_have_tx) begin
                        w_res.send_code = SND_EOT;
                        n_link.tmo      = i_cfg.idle_to;
                        n_link.st       = ST_IDLE;
                    end else begin
                        w_res.send_code = SND_DATA;
                    end
                end
                ST_RECV: begin
                    n_link.tmo  = w_tmo_recv_bo;
                    n_link.tcnt = w_tcnt_inc;
                    if (w_tcnt_inc >= i_cfg.max_to) begin
                        n_link.tmo = i_cfg.idle_to;
                        n_link.st  = ST_IDLE;
                    end
                end
                default: n_link.st = ST_IDLE;
            endcase
        end else begin
            unique case (r_link.st)
                ST_BID: begin
                    w_res.read_result = RR_CTRL;
                    if (i_item.ctrl_kind == K_ACK) begin
                        n_link.tcnt  = '0;
                        n_link.fbcnt = '0;
                        if (!w_have_tx) begin
                            w_res.send_code = SND_EOT;
                            n_link.tmo      = i_cfg.idle_to;
                            n_link.st       = ST_IDLE;
                        end else begin
                            w_res.send_code = SND_DATA;
                            n_link.tmo      = i_cfg.send_to;
                            n_link.st       = ST_SEND;
                        end
                    end else begin
                        n_link.tmo = i_cfg.idle_to;
                        n_link.st  = ST_IDLE;
                    end
                end
                ST_SEND: begin
                    w_res.read_result = RR_CTRL;
                    if (i_item.ctrl_kind == K_ACK) begin
                        w_res.pop_tx = w_have_tx;
                        if (w_left == 8'd0) begin
                            w_res.send_code = SND_EOT;
                            n_link.tmo      = i_cfg.idle_to;
                            n_link.st       = ST_IDLE;
                        end else begin
                            w_res.send_code = SND_DATA;
                        end
                    end else if (i_item.ctrl_kind == K_RVI) begin
                        // Peer wants the line: hand it over
                        w_res.pop_tx    = w_have_tx;
                        w_res.send_code = SND_ACK;
                        n_link.st       = ST_RECV;
                        n_link.tmo      = i_cfg.recv_to;
                        n_link.tcnt     = '0;
                    end else begin
                        // Unexpected frame: drop to idle, timeout kept
                        n_link.st = ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    w_res.read_result = RR_CTRL;
                    if (i_item.ctrl_kind == K_ENQ) begin
                        w_res.send_code = SND_ACK;
                        n_link.st       = ST_RECV;
                        n_link.tmo      = i_cfg.recv_to;
                    end
                end
                ST_RECV: begin
                    if (i_item.ctrl_kind == K_EOT) begin
                        w_res.read_result = RR_CTRL;
                        n_link.st         = ST_IDLE;
                        n_link.tmo        = i_cfg.idle_to;
                    end else if (!i_item.lead_is_soh) begin
                        w_res.read_result = RR_INVALID;
                        n_link.st         = ST_IDLE;
                    end else if (!i_item.frame_complete) begin
                        w_res.read_result = RR_UNFINISH;
                    end else begin
                        w_res.read_result = RR_DATA;
                        if (i_item.crc_ok && (i_item.seq_byte == {7'd0, r_link.seq})) begin
                            w_res.deliver_rx = 1'b1;
                            n_link.seq       = ~r_link.seq;
                            if (w_have_tx) begin
                                w_res.send_code = SND_RVI;
                                n_link.st       = ST_BID;
                            end else begin
                                w_res.send_code = SND_ACK;
                            end
                        end
                    end
                end
                default: n_link.st = ST_IDLE;
            endcase
        end

        w_res.next_state    = enc_state(n_link.st);
        w_res.timeout_value = n_link.tmo;
    end

    // Advance the link state as each request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.st    <= ST_IDLE;
            r_link.tmo   <= IDLE_TO_RST;
            r_link.tcnt  <= '0;
            r_link.fbcnt <= '0;
            r_link.seq   <= 1'b0;
        end else if (i_adv) begin
            r_link <= n_link;
        end
    end

    assign o_res = w_res;

endmodule
